[design/dltq_pkg.sv]
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta-list timer queue
// Field widths, mode and status codes, and the command word that is passed
// from the front end to the list engine.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int QDEPTH_DEF  = 2;

  localparam int ID_W    = 4;
  localparam int DELAY_W = 40;
  localparam int TIME_W  = 48;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  // Upper bound on expiry words reported for one tick.
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXPIRED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd3;

  localparam logic [DELAY_W-1:0] ETERNITY = {DELAY_W{1'b1}};

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [ID_W-1:0]      id;
    logic [DELAY_W-1:0]   delay;
    logic [TIME_W-1:0]    now;
  } cmd_t;

endpackage

[design/dltq_front.sv]
// ----------------------------------------------------------------------------
// dltq_front: input word decode
// Takes input words, unpacks the fields and folds the four modes into the
// three command kinds the list engine knows.
// ----------------------------------------------------------------------------
module dltq_front
  import dltq_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  push,
  output cmd_t                  push_cmd,
  input  logic                  q_full
);

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_cmd.id    = in_tdata[ID_W-1:0];
    push_cmd.delay = in_tdata[ID_W+DELAY_W-1:ID_W];
    push_cmd.now   = in_tdata[ID_W+DELAY_W+TIME_W-1:ID_W+DELAY_W];
    case (in_tuser)
      MODE_ADD, MODE_UPDATE: begin
        push_cmd.kind = OP_SET;
      end
      MODE_REMOVE: begin
        push_cmd.kind = OP_REMOVE;
      end
      default: begin
        push_cmd.kind = OP_TICK;
      end
    endcase
  end

endmodule

[design/dltq_queue.sv]
// ----------------------------------------------------------------------------
// dltq_queue: command queue
// Small FIFO of decoded commands between the front end and the list engine.
// ----------------------------------------------------------------------------
module dltq_queue
  import dltq_pkg::*;
#(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

[design/dltq_engine.sv]
// ----------------------------------------------------------------------------
// dltq_engine: delta-list engine
// Keeps the list in a row of slots that rotates through the head, one slot per
// cycle but in S_HOLD, so that sync, removal and insertion happen in one sweep.
// ----------------------------------------------------------------------------
module dltq_engine
  import dltq_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STAT_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  // One spare slot: an update of a full list can insert the new timer
  // before the sweep has reached and dropped the old one.
  localparam int NSLOT = ENTRIES + 1;
  localparam int CW    = $clog2(ENTRIES + 2);
  localparam int IW    = $clog2(NSLOT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PASS = 6'b000010,
    S_HOLD = 6'b000100,
    S_FIN  = 6'b001000,
    S_EXP  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [ID_W-1:0]    ids_r [NSLOT];
  logic [DELAY_W-1:0] dl_r  [NSLOT];

  logic [CW-1:0]      count_r, count_nxt, rem_r, rem_nxt;
  logic [15:0]        mask_r, mask_nxt;
  logic [TIME_W-1:0]  last_r, last_nxt;
  logic [TIME_W-1:0]  el_r, el_nxt;
  logic               sync_r, sync_nxt;
  logic [DELAY_W-1:0] carry_r, carry_nxt;
  logic [DELAY_W-1:0] d_r, d_nxt;
  logic [ID_W-1:0]    tgt_r, tgt_nxt;
  logic               tgt_en_r, tgt_en_nxt;
  logic               ins_en_r, ins_en_nxt;
  logic               ins_done_r, ins_done_nxt;
  logic               tick_r, tick_nxt;
  logic [ID_W-1:0]    hold_id_r, hold_id_nxt;
  logic [DELAY_W-1:0] hold_d_r, hold_d_nxt;
  logic [NRES_W-1:0]  n_r, n_nxt;

  logic [STAT_W-1:0]  res_st_r, res_st_nxt;
  logic [ID_W-1:0]    res_id_r, res_id_nxt;
  logic [DELAY_W-1:0] res_ttn_r, res_ttn_nxt;
  logic               res_last_r, res_last_nxt;

  logic               ov_r, ov_nxt;
  logic [STAT_W-1:0]  o_st_r, o_st_nxt;
  logic [ID_W-1:0]    o_id_r, o_id_nxt;
  logic [DELAY_W-1:0] o_ttn_r, o_ttn_nxt;
  logic               o_last_r, o_last_nxt;

  logic               shift_pop, shift_push;
  logic [ID_W-1:0]    wr_id;
  logic [DELAY_W-1:0] wr_d;
  logic [CW-1:0]      wpos;
  logic [IW-1:0]      wi;

  logic [DELAY_W-1:0] head_d, de1, de2;
  logic               queued;

  assign head_d = (count_r != '0) ? dl_r[0] : ETERNITY;
  assign queued = mask_r[q_cmd.id];
  assign de1    = dl_r[0] + carry_r;
  assign wpos   = (shift_pop && shift_push) ? count_r - 1'b1 : count_r;
  assign wi     = wpos[IW-1:0];

  assign out_tvalid = ov_r;
  assign out_tuser  = o_st_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {{(OUT_DATA_W - ID_W - DELAY_W){1'b0}}, o_ttn_r, o_id_r};

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    count_nxt    = count_r;
    rem_nxt      = rem_r;
    mask_nxt     = mask_r;
    last_nxt     = last_r;
    el_nxt       = el_r;
    sync_nxt     = sync_r;
    carry_nxt    = carry_r;
    d_nxt        = d_r;
    tgt_nxt      = tgt_r;
    tgt_en_nxt   = tgt_en_r;
    ins_en_nxt   = ins_en_r;
    ins_done_nxt = ins_done_r;
    tick_nxt     = tick_r;
    hold_id_nxt  = hold_id_r;
    hold_d_nxt   = hold_d_r;
    n_nxt        = n_r;
    res_st_nxt   = res_st_r;
    res_id_nxt   = res_id_r;
    res_ttn_nxt  = res_ttn_r;
    res_last_nxt = res_last_r;
    ov_nxt       = ov_r && !out_tready;
    o_st_nxt     = o_st_r;
    o_id_nxt     = o_id_r;
    o_ttn_nxt    = o_ttn_r;
    o_last_nxt   = o_last_r;
    pop          = 1'b0;
    shift_pop    = 1'b0;
    shift_push   = 1'b0;
    wr_id        = hold_id_r;
    wr_d         = hold_d_r;
    de2          = de1;

    // Sync on the element at the head, after any folded delta is added.
    if (sync_r) begin
      if (el_r >= {{(TIME_W - DELAY_W){1'b0}}, de1}) begin
        de2 = '0;
      end else begin
        de2 = de1 - el_r[DELAY_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop          = 1'b1;
          carry_nxt    = '0;
          ins_done_nxt = 1'b0;
          d_nxt        = q_cmd.delay;
          tgt_nxt      = q_cmd.id;
          rem_nxt      = count_r;
          n_nxt        = '0;
          tick_nxt     = 1'b0;
          ins_en_nxt   = 1'b0;
          tgt_en_nxt   = 1'b0;
          sync_nxt     = 1'b0;
          res_id_nxt   = '0;
          res_ttn_nxt  = head_d;
          res_last_nxt = 1'b1;
          ret_nxt      = S_IDLE;
          case (q_cmd.kind)
            OP_SET: begin
              if (!queued && count_r == CW'(ENTRIES)) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_OUT;
              end else begin
                tgt_en_nxt = queued;
                ins_en_nxt = 1'b1;
                mask_nxt[q_cmd.id] = 1'b1;
                last_nxt   = q_cmd.now;
                sync_nxt   = (q_cmd.now >= last_r);
                el_nxt     = q_cmd.now - last_r;
                state_nxt  = S_PASS;
              end
            end
            OP_REMOVE: begin
              if (!queued) begin
                res_st_nxt = ST_ABSENT;
                state_nxt  = S_OUT;
              end else begin
                tgt_en_nxt = 1'b1;
                mask_nxt[q_cmd.id] = 1'b0;
                state_nxt  = S_PASS;
              end
            end
            default: begin
              tick_nxt = 1'b1;
              // A due head skips the sync and keeps the old sync time.
              if (count_r == '0 || dl_r[0] != '0) begin
                last_nxt = q_cmd.now;
                sync_nxt = (q_cmd.now >= last_r);
                el_nxt   = q_cmd.now - last_r;
              end
              state_nxt = S_PASS;
            end
          endcase
        end
      end

      S_PASS: begin
        if (rem_r != '0) begin
          shift_pop = 1'b1;
          rem_nxt   = rem_r - 1'b1;
          if (tgt_en_r && ids_r[0] == tgt_r) begin
            // Removed entry: its delta moves on to the successor.
            carry_nxt = dl_r[0];
          end else begin
            carry_nxt = '0;
            if (sync_r) begin
              if (el_r >= {{(TIME_W - DELAY_W){1'b0}}, de1}) begin
                el_nxt = el_r - {{(TIME_W - DELAY_W){1'b0}}, de1};
              end else begin
                sync_nxt = 1'b0;
              end
            end
            shift_push = 1'b1;
            if (ins_en_r && !ins_done_r && d_r < de2) begin
              // New entry lands ahead of this one; this one is held and written in S_HOLD.
              wr_id        = tgt_r;
              wr_d         = d_r;
              hold_id_nxt  = ids_r[0];
              hold_d_nxt   = de2 - d_r;
              ins_done_nxt = 1'b1;
              state_nxt    = S_HOLD;
            end else begin
              if (ins_en_r && !ins_done_r) begin
                d_nxt = d_r - de2;
              end
              wr_id = ids_r[0];
              wr_d  = de2;
            end
          end
        end else begin
          if (ins_en_r && !ins_done_r) begin
            shift_push   = 1'b1;
            wr_id        = tgt_r;
            wr_d         = d_r;
            ins_done_nxt = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end

      S_HOLD: begin
        shift_push = 1'b1;
        state_nxt  = S_PASS;
      end

      S_FIN: begin
        if (tick_r) begin
          state_nxt = S_EXP;
        end else begin
          res_st_nxt   = ST_DONE;
          res_id_nxt   = '0;
          res_ttn_nxt  = head_d;
          res_last_nxt = 1'b1;
          ret_nxt      = S_IDLE;
          state_nxt    = S_OUT;
        end
      end

      S_EXP: begin
        if (count_r != '0 && dl_r[0] == '0 && n_r < NRES_W'(MAX_RESULTS)) begin
          shift_pop = 1'b1;
          mask_nxt[ids_r[0]] = 1'b0;
          n_nxt        = n_r + 1'b1;
          res_st_nxt   = ST_EXPIRED;
          res_id_nxt   = ids_r[0];
          res_ttn_nxt  = (count_r > CW'(1)) ? dl_r[1] : ETERNITY;
          res_last_nxt = !(count_r > CW'(1) && dl_r[1] == '0 &&
                           n_r < NRES_W'(MAX_RESULTS - 1));
          ret_nxt      = res_last_nxt ? S_IDLE : S_EXP;
          state_nxt    = S_OUT;
        end else if (n_r == '0) begin
          res_st_nxt   = ST_DONE;
          res_id_nxt   = '0;
          res_ttn_nxt  = head_d;
          res_last_nxt = 1'b1;
          ret_nxt      = S_IDLE;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt     = 1'b1;
          o_st_nxt   = res_st_r;
          o_id_nxt   = res_id_r;
          o_ttn_nxt  = res_ttn_r;
          o_last_nxt = res_last_r;
          state_nxt  = ret_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (shift_pop && !shift_push) begin
      count_nxt = count_r - 1'b1;
    end else if (shift_push && !shift_pop) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      count_r <= '0;
      mask_r  <= '0;
      last_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      count_r <= count_nxt;
      mask_r  <= mask_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    el_r       <= el_nxt;
    sync_r     <= sync_nxt;
    carry_r    <= carry_nxt;
    d_r        <= d_nxt;
    tgt_r      <= tgt_nxt;
    tgt_en_r   <= tgt_en_nxt;
    ins_en_r   <= ins_en_nxt;
    ins_done_r <= ins_done_nxt;
    tick_r     <= tick_nxt;
    hold_id_r  <= hold_id_nxt;
    hold_d_r   <= hold_d_nxt;
    n_r        <= n_nxt;
    res_st_r   <= res_st_nxt;
    res_id_r   <= res_id_nxt;
    res_ttn_r  <= res_ttn_nxt;
    res_last_r <= res_last_nxt;
    o_st_r     <= o_st_nxt;
    o_id_r     <= o_id_nxt;
    o_ttn_r    <= o_ttn_nxt;
    o_last_r   <= o_last_nxt;
  end

  // Slot row: a pop moves every slot one place toward the head, a push
  // writes the tail.
  for (genvar j = 0; j < NSLOT; j++) begin : g_slot
    if (j < NSLOT - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (shift_push && wi == IW'(j)) begin
          ids_r[j] <= wr_id;
          dl_r[j]  <= wr_d;
        end else if (shift_pop) begin
          ids_r[j] <= ids_r[j+1];
          dl_r[j]  <= dl_r[j+1];
        end
      end
    end else begin : g_end
      always_ff @(posedge clk) begin
        if (shift_push && wi == IW'(j)) begin
          ids_r[j] <= wr_id;
          dl_r[j]  <= wr_d;
        end
      end
    end
  end

endmodule

[design/delta_list_timer_queue.sv]
// ----------------------------------------------------------------------------
// delta_list_timer_queue: timer queue kept as a delta list
// Adds, updates and removes timers by id and reports expired timers on tick.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Contents
//   in_      slave      in_tvalid/in_tready  tuser: mode; tdata: id, delay, now
//   out_     master     out_tvalid/out_tready tuser: status; tdata: id, next;
//                                             tlast: final word of an item
//
// An add, update or remove sweeps the whole list of queued timers, and pauses
// in a hold state when the new timer lands ahead of an existing one. A tick
// sweeps the list, then sends one word per expiry, up to MAX_RESULTS, or a
// single done word when nothing is due. The list sweep rotates one slot per
// cycle through the head of the slot row, but for the hold state. A full
// queue or an unknown id on remove is answered without a sweep.
// Reset (synchronous, active low) empties the queue and zeroes the sync time.
// A two-word command queue lets input words be taken while the engine works
// or while a result word waits for out_tready.
//
module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_id[3:0], delay[43:4], now_time[91:44]
  input  logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // expired_id[3:0], time_to_next[43:4]
  output logic [STAT_W-1:0]     out_tuser,  // status[1:0]
  output logic                  out_tlast
);

  logic push, q_full, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  dltq_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  // Commands wait here until the engine has finished the previous one.
  dltq_queue #(
    .DEPTH (QDEPTH_DEF)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  dltq_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[design/dltq_chk.sv]
// ----------------------------------------------------------------------------
// dltq_chk: port checker
// Checks result words on the top level ports.
// ----------------------------------------------------------------------------
module dltq_chk
  import dltq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser,
  input logic                  out_tlast
);

  // A waiting result word is not withdrawn.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // Only expiry words carry an id.
  a_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_EXPIRED |-> out_tdata[ID_W-1:0] == '0)
    else $error("id set on a word that is not an expiry");

  // Every item other than a tick with expiries gives exactly one word.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_EXPIRED |-> out_tlast)
    else $error("non-expiry word without tlast");

  // Nothing is offered right after reset.
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

endmodule

bind delta_list_timer_queue dltq_chk u_chk (.*);
